### rtl/dci_pkg.sv
// Package for the dual-context interrupt controller: sizes, codes, word types.
// Used by dci_decode, dci_regfile and dual_cpu_interrupt_controller_top.
`timescale 1ns / 1ps
package dci_pkg;

	localparam int NUM_BANKS    = 3;
	localparam int NUM_CONTEXTS = 2;
	localparam int SLOTS        = NUM_CONTEXTS * NUM_BANKS;
	localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CTX_W        = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_RAISE = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam logic [3:0] KIND_LATCHED = 4'h0;
	localparam logic [3:0] KIND_RAW     = 4'h4;
	localparam logic [3:0] KIND_MASK    = 4'h8;

	localparam logic [1:0] RSEL_LATCHED = 2'd0;
	localparam logic [1:0] RSEL_RAW     = 2'd1;
	localparam logic [1:0] RSEL_MASK    = 2'd2;

	typedef struct packed {
		logic [1:0]  opcode;
		logic        cpu_select;
		logic [5:0]  reg_offset;
		logic [31:0] write_data;
		logic [6:0]  source_number;
	} req_word_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        bad_access;
		logic        main_pending;
		logic        me_pending;
	} rsp_word_t;

	typedef struct packed {
		logic              rd;
		logic [1:0]        rd_sel;
		logic              wr_latched;
		logic              wr_mask;
		logic              raise;
		logic              clear;
		logic              bad;
		logic [SLOT_W-1:0] slot;
		logic [CTX_W-1:0]  ctx;
		logic [31:0]       data;
		logic [31:0]       bit_mask;
	} cmd_t;

endpackage

### rtl/dual_cpu_interrupt_controller_top.sv
// A request word passes through the input register and then the response register.
// Throughput: one word per cycle; the input register and the response register
// advance together, so the rate is set only by the response side's stall.
// Reset (arst_n low) clears all flags, masks and pending levels and empties both
// registers; the block accepts words in the first cycle after reset is released.
`timescale 1ns / 1ps
module dual_cpu_interrupt_controller_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  dci_pkg::req_word_t req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output dci_pkg::rsp_word_t rsp
);

	dci_pkg::req_word_t req_s1;
	logic               valid_s1;
	logic               adv;
	dci_pkg::cmd_t      cmd;
	logic [31:0]        rdata;
	logic               main_pend;
	logic               me_pend;
	dci_pkg::rsp_word_t rsp_q;
	logic               rsp_valid_q;

	assign adv       = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	dci_decode u_decode (
		.req (req_s1),
		.cmd (cmd)
	);

	dci_regfile u_regfile (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (adv),
		.cmd          (cmd),
		.read_data    (rdata),
		.main_pending (main_pend),
		.me_pending   (me_pend)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q.read_data    <= rdata;
			rsp_q.bad_access   <= cmd.bad;
			rsp_q.main_pending <= main_pend;
			rsp_q.me_pending   <= me_pend;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1 && rsp_valid_q)
		else $error("input stalled with no word held");

	a_bad_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.bad_access && rsp.read_data != 32'd0))
		else $error("refused access returned data");

	a_adv_fills_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> rsp_valid_q)
		else $error("advanced word lost before response register");

endmodule

### rtl/dci_decode.sv
// Decode of one request word into a register-file command.
// Depends on dci_pkg.
`timescale 1ns / 1ps
module dci_decode (
	input  dci_pkg::req_word_t req,
	output dci_pkg::cmd_t      cmd
);

	logic       bus;
	logic       ctx_eff;
	logic [1:0] bank_sel;
	logic [3:0] kind;
	logic       ctx_ok;
	logic       bank_ok;
	logic       kind_ok;
	logic       bad;

	always_comb begin
		bus      = (req.opcode == dci_pkg::OP_READ) || (req.opcode == dci_pkg::OP_WRITE);
		kind     = req.reg_offset[3:0];
		bank_sel = bus ? req.reg_offset[5:4] : req.source_number[6:5];
		ctx_eff  = (req.opcode == dci_pkg::OP_CLEAR) ? 1'b0 : req.cpu_select;
		ctx_ok   = 32'(ctx_eff) < 32'(dci_pkg::NUM_CONTEXTS);
		bank_ok  = 32'(bank_sel) < 32'(dci_pkg::NUM_BANKS);
		case (req.opcode)
			dci_pkg::OP_READ: begin
				kind_ok = (kind == dci_pkg::KIND_LATCHED) || (kind == dci_pkg::KIND_RAW) ||
					(kind == dci_pkg::KIND_MASK);
			end
			dci_pkg::OP_WRITE: begin
				kind_ok = (kind == dci_pkg::KIND_LATCHED) || (kind == dci_pkg::KIND_MASK);
			end
			default: begin
				kind_ok = 1'b1;
			end
		endcase
		bad = !ctx_ok || !bank_ok || !kind_ok;

		cmd.bad        = bad;
		cmd.rd         = !bad && (req.opcode == dci_pkg::OP_READ);
		cmd.wr_latched = !bad && (req.opcode == dci_pkg::OP_WRITE) &&
			(kind == dci_pkg::KIND_LATCHED);
		cmd.wr_mask    = !bad && (req.opcode == dci_pkg::OP_WRITE) &&
			(kind == dci_pkg::KIND_MASK);
		cmd.raise      = !bad && (req.opcode == dci_pkg::OP_RAISE);
		cmd.clear      = !bad && (req.opcode == dci_pkg::OP_CLEAR);
		case (kind)
			dci_pkg::KIND_RAW:  cmd.rd_sel = dci_pkg::RSEL_RAW;
			dci_pkg::KIND_MASK: cmd.rd_sel = dci_pkg::RSEL_MASK;
			default:            cmd.rd_sel = dci_pkg::RSEL_LATCHED;
		endcase
		cmd.slot     = dci_pkg::SLOT_W'(int'(ctx_eff) * dci_pkg::NUM_BANKS + int'(bank_sel));
		cmd.ctx      = dci_pkg::CTX_W'(ctx_eff);
		cmd.data     = req.write_data;
		cmd.bit_mask = 32'd1 << req.source_number[4:0];
	end

endmodule

### rtl/dci_regfile.sv
// Flag and mask register file with per-context pending levels.
// Depends on dci_pkg; driven by a command from dci_decode.
`timescale 1ns / 1ps
module dci_regfile (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  dci_pkg::cmd_t  cmd,
	output logic [31:0]    read_data,
	output logic           main_pending,
	output logic           me_pending
);

	logic [31:0] latched_q [dci_pkg::SLOTS];
	logic [31:0] raw_q     [dci_pkg::SLOTS];
	logic [31:0] mask_q    [dci_pkg::SLOTS];
	logic [31:0] latched_d [dci_pkg::SLOTS];
	logic [31:0] raw_d     [dci_pkg::SLOTS];
	logic [31:0] mask_d    [dci_pkg::SLOTS];
	logic [dci_pkg::NUM_CONTEXTS-1:0] pend_q;
	logic [dci_pkg::NUM_CONTEXTS-1:0] pend_d;
	logic [dci_pkg::NUM_CONTEXTS-1:0] or_d;
	logic [dci_pkg::NUM_CONTEXTS-1:0] or_cur;
	logic        raise_hit;
	logic        recompute;
	logic        stray;

	always_comb begin
		raise_hit = 1'b0;
		stray     = 1'b0;
		for (int s = 0; s < dci_pkg::SLOTS; s++) begin
			latched_d[s] = latched_q[s];
			raw_d[s]     = raw_q[s];
			mask_d[s]    = mask_q[s];
			stray        = stray | (|(latched_q[s] & ~raw_q[s]));
			if (cmd.slot == dci_pkg::SLOT_W'(s)) begin
				if (cmd.wr_latched) begin
					latched_d[s] = latched_q[s] & ~cmd.data;
					raw_d[s]     = raw_q[s] & ~cmd.data;
				end
				if (cmd.wr_mask) begin
					mask_d[s]    = cmd.data;
					latched_d[s] = latched_q[s] | (cmd.data & raw_q[s]);
				end
				if (cmd.raise) begin
					raw_d[s] = raw_q[s] | cmd.bit_mask;
					if (|(mask_q[s] & cmd.bit_mask)) begin
						latched_d[s] = latched_q[s] | cmd.bit_mask;
						raise_hit    = 1'b1;
					end
				end
				if (cmd.clear) begin
					latched_d[s] = latched_q[s] & ~cmd.bit_mask;
					raw_d[s]     = raw_q[s] & ~cmd.bit_mask;
				end
			end
		end
	end

	always_comb begin
		recompute = cmd.wr_latched || cmd.wr_mask || cmd.clear;
		for (int c = 0; c < dci_pkg::NUM_CONTEXTS; c++) begin
			or_d[c]   = 1'b0;
			or_cur[c] = 1'b0;
			for (int b = 0; b < dci_pkg::NUM_BANKS; b++) begin
				or_d[c]   = or_d[c] | (|(latched_d[c * dci_pkg::NUM_BANKS + b] &
					mask_d[c * dci_pkg::NUM_BANKS + b]));
				or_cur[c] = or_cur[c] | (|(latched_q[c * dci_pkg::NUM_BANKS + b] &
					mask_q[c * dci_pkg::NUM_BANKS + b]));
			end
			pend_d[c] = pend_q[c];
			if (cmd.ctx == dci_pkg::CTX_W'(c)) begin
				if (recompute) begin
					pend_d[c] = or_d[c];
				end
				if (cmd.raise && raise_hit) begin
					pend_d[c] = 1'b1;
				end
			end
		end
	end

	always_comb begin
		read_data = 32'd0;
		if (cmd.rd) begin
			case (cmd.rd_sel)
				dci_pkg::RSEL_LATCHED: read_data = latched_q[cmd.slot];
				dci_pkg::RSEL_RAW:     read_data = raw_q[cmd.slot];
				dci_pkg::RSEL_MASK:    read_data = mask_q[cmd.slot];
				default:               read_data = 32'd0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < dci_pkg::SLOTS; s++) begin
				latched_q[s] <= 32'd0;
				raw_q[s]     <= 32'd0;
				mask_q[s]    <= 32'd0;
			end
			pend_q <= '0;
		end else if (en) begin
			for (int s = 0; s < dci_pkg::SLOTS; s++) begin
				latched_q[s] <= latched_d[s];
				raw_q[s]     <= raw_d[s];
				mask_q[s]    <= mask_d[s];
			end
			pend_q <= pend_d;
		end
	end

	assign main_pending = pend_d[0];

	generate
		if (dci_pkg::NUM_CONTEXTS > 1) begin : g_me
			assign me_pending = pend_d[1];
		end else begin : g_no_me
			assign me_pending = 1'b0;
		end
	endgenerate

	a_latched_in_raw: assert property (@(posedge clk) disable iff (!arst_n)
		!stray)
		else $error("latched flag set without raw flag");

	a_main_pending_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q[0] == or_cur[0])
		else $error("main pending level out of step with latched and mask");

	a_read_only_on_rd: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.rd |-> read_data == 32'd0)
		else $error("read data driven without a read");

endmodule
